[hw/rtl/sed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder package
// Transaction types, character codes and sizing constants shared by the
// decoder stage, the result queue and the top level.
// ----------------------------------------------------------------------------
package sed_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 8;
	localparam int MAX_RESULTS     = 3;
	localparam int PUSH_BITS       = 2;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BEL       = 8'h07;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_VT        = 8'h0B;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_F   = 8'h46;
	localparam logic [7:0] CH_UPPER_X   = 8'h58;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_B   = 8'h62;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_S   = 8'h73;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_V   = 8'h76;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;

	localparam logic [1:0] DEC_DIGITS = 2'd3;
	localparam logic [1:0] HEX_DIGITS = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_terminator;
		logic [15:0] string_length;
	} out_item_t;

	typedef struct packed {
		logic [PUSH_BITS-1:0]             count;
		out_item_t [MAX_RESULTS-1:0]      item;
	} push_t;

endpackage

`default_nettype wire

[hw/rtl/sed_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder stage
// Registers one input byte, runs the escape state machine on it and hands
// up to three decoded results per byte to the result queue.
// ----------------------------------------------------------------------------
module sed_decoder
	import sed_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     literal_valid,
	output logic          literal_stall,
	input  wire in_item_t literal,
	input  wire logic     room,
	output push_t         push
);

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_DEC   = 2'd2,
		MODE_HEX   = 2'd3
	} mode_t;

	localparam int SUM_BITS = LENGTH_BITS + 1;
	localparam int EXT_BITS = LENGTH_BITS + 16;

	logic                   valid_s1;
	in_item_t               item_s1;
	logic                   advance;

	mode_t                  mode_q;
	logic [7:0]             value_q;
	logic [1:0]             digits_q;
	logic                   skip_q;
	logic [LENGTH_BITS-1:0] count_q;

	mode_t                  mode_d;
	logic [7:0]             value_d;
	logic [1:0]             digits_d;
	logic                   skip_d;
	logic [LENGTH_BITS-1:0] count_d;

	logic [2:0][7:0]        eb;
	logic [1:0]             en;
	logic [LENGTH_BITS-1:0] term_count;
	logic [15:0]            term_length;

	assign literal_stall = valid_s1 && !room;
	assign advance       = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!literal_stall) begin
			valid_s1 <= literal_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!literal_stall) begin
			item_s1 <= literal;
		end
	end

	always_comb begin
		logic [7:0]          c;
		logic                last;
		logic                dec_ok;
		logic                hex_ok;
		logic [3:0]          dig;
		logic [3:0]          hexv;
		logic                run_plain;
		logic [SUM_BITS-1:0] sum;
		logic [EXT_BITS-1:0] ext;

		c         = item_s1.in_byte;
		last      = item_s1.end_of_string;
		mode_d    = mode_q;
		value_d   = value_q;
		digits_d  = digits_q;
		skip_d    = skip_q;
		eb        = '0;
		en        = 2'd0;
		run_plain = 1'b0;

		dec_ok = (c >= CH_ZERO) && (c <= CH_NINE);
		dig    = 4'(c - CH_ZERO);
		hex_ok = 1'b1;
		if (dec_ok) begin
			hexv = dig;
		end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
			hexv = 4'(c - CH_LOWER_A + 8'd10);
		end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
			hexv = 4'(c - CH_UPPER_A + 8'd10);
		end else begin
			hexv   = 4'd0;
			hex_ok = 1'b0;
		end

		case (mode_q)
			MODE_ESC: begin
				mode_d = MODE_PLAIN;
				if (dec_ok) begin
					mode_d   = MODE_DEC;
					value_d  = {4'd0, dig};
					digits_d = 2'd1;
				end else if ((c == CH_LOWER_X) || (c == CH_UPPER_X)) begin
					mode_d   = MODE_HEX;
					value_d  = 8'd0;
					digits_d = 2'd0;
				end else begin
					case (c)
						CH_CR:        skip_d = 1'b1;
						CH_LOWER_A:   begin eb[0] = CH_BEL;       en = 2'd1; end
						CH_LOWER_B:   begin eb[0] = CH_BS;        en = 2'd1; end
						CH_LOWER_F:   begin eb[0] = CH_FF;        en = 2'd1; end
						CH_LOWER_N:   begin eb[0] = CH_LF;        en = 2'd1; end
						CH_LOWER_R:   begin eb[0] = CH_CR;        en = 2'd1; end
						CH_LOWER_S:   begin eb[0] = CH_SPACE;     en = 2'd1; end
						CH_LOWER_T:   begin eb[0] = CH_TAB;       en = 2'd1; end
						CH_LOWER_V:   begin eb[0] = CH_VT;        en = 2'd1; end
						CH_SQUOTE:    begin eb[0] = CH_SQUOTE;    en = 2'd1; end
						CH_DQUOTE:    begin eb[0] = CH_DQUOTE;    en = 2'd1; end
						CH_BACKSLASH: begin eb[0] = CH_BACKSLASH; en = 2'd1; end
						default: begin
							eb[0] = CH_BACKSLASH;
							eb[1] = c;
							en    = 2'd2;
						end
					endcase
				end
			end
			MODE_DEC: begin
				if (dec_ok && (digits_q < DEC_DIGITS)) begin
					value_d  = 8'(value_q * 8'd10 + {4'd0, dig});
					digits_d = digits_q + 2'd1;
					if (digits_d >= DEC_DIGITS) begin
						eb[0]    = value_d;
						en       = 2'd1;
						mode_d   = MODE_PLAIN;
						value_d  = 8'd0;
						digits_d = 2'd0;
					end
				end else begin
					eb[0]     = value_q;
					en        = 2'd1;
					mode_d    = MODE_PLAIN;
					value_d   = 8'd0;
					digits_d  = 2'd0;
					run_plain = 1'b1;
				end
			end
			MODE_HEX: begin
				if (hex_ok && (digits_q < HEX_DIGITS)) begin
					value_d  = {value_q[3:0], hexv};
					digits_d = digits_q + 2'd1;
					if (digits_d >= HEX_DIGITS) begin
						eb[0]    = value_d;
						en       = 2'd1;
						mode_d   = MODE_PLAIN;
						value_d  = 8'd0;
						digits_d = 2'd0;
					end
				end else begin
					eb[0]     = value_q;
					en        = 2'd1;
					mode_d    = MODE_PLAIN;
					value_d   = 8'd0;
					digits_d  = 2'd0;
					run_plain = 1'b1;
				end
			end
			default: begin
				run_plain = 1'b1;
			end
		endcase

		if (run_plain) begin
			if (skip_d && (c == CH_LF)) begin
				skip_d = 1'b0;
			end else begin
				skip_d = 1'b0;
				if (c == CH_BACKSLASH) begin
					mode_d = MODE_ESC;
				end else if (c == CH_CR) begin
					eb[en] = CH_LF;
					en     = en + 2'd1;
					skip_d = 1'b1;
				end else begin
					eb[en] = c;
					en     = en + 2'd1;
				end
			end
		end

		if (last) begin
			if (mode_d == MODE_ESC) begin
				eb[en] = CH_BACKSLASH;
				en     = en + 2'd1;
			end else if ((mode_d == MODE_DEC) || (mode_d == MODE_HEX)) begin
				eb[en] = value_d;
				en     = en + 2'd1;
			end
		end

		sum = {1'b0, count_q} + SUM_BITS'(en);
		if (sum > {1'b0, {LENGTH_BITS{1'b1}}}) begin
			term_count = {LENGTH_BITS{1'b1}};
		end else begin
			term_count = sum[LENGTH_BITS-1:0];
		end

		ext = {16'd0, term_count};
		if (ext > EXT_BITS'(16'hFFFF)) begin
			term_length = 16'hFFFF;
		end else begin
			term_length = ext[15:0];
		end

		if (last) begin
			mode_d   = MODE_PLAIN;
			value_d  = 8'd0;
			digits_d = 2'd0;
			skip_d   = 1'b0;
			count_d  = '0;
		end else begin
			count_d  = term_count;
		end

		for (int i = 0; i < MAX_RESULTS; i++) begin
			push.item[i].is_terminator = last && (2'(i) == en);
			push.item[i].out_byte      = (2'(i) < en) ? eb[i] : CH_NUL;
			push.item[i].string_length = push.item[i].is_terminator ? term_length : 16'd0;
		end
		push.count = advance ? (en + {1'b0, last}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			value_q  <= 8'd0;
			digits_q <= 2'd0;
			skip_q   <= 1'b0;
			count_q  <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			value_q  <= value_d;
			digits_q <= digits_d;
			skip_q   <= skip_d;
			count_q  <= count_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sed_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder result queue
// Small register queue that takes up to three results per cycle and hands
// out one result transaction per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module sed_out_queue
	import sed_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       decoded_valid,
	input  wire logic  decoded_stall,
	output out_item_t  decoded
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	out_item_t     mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign decoded_valid = (count_q != '0);
	assign decoded       = mem_q[rd_q];
	assign pop           = decoded_valid && !decoded_stall;
	assign room          = (count_q <= CW'(DEPTH - MAX_RESULTS));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (PUSH_BITS'(i) < push.count) begin
				mem_q[PW'(wr_q + PW'(i))] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= PW'(wr_q + PW'(push.count));
			rd_q    <= PW'(rd_q + PW'(pop));
			count_q <= CW'(count_q + CW'(push.count) - CW'(pop));
		end
	end

endmodule

`default_nettype wire

[hw/rtl/string_escape_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder
// Decodes backslash escapes and line endings of a string literal, one raw
// byte per literal transaction, into decoded bytes and a NUL terminator.
//
// The literal channel carries one raw byte and its end-of-string flag. The
// decoded channel carries one result per transaction: a decoded byte, or
// the terminator with the saturated decoded length. One literal byte gives
// zero to three results. A byte enters the input register at acceptance and
// is decoded there; its results are written to the result queue when the
// queue has room, and are offered from the queue in order. One byte is
// taken every cycle while the eight-entry result queue has room for three
// more results; the queue drains one result per cycle, so a receiver that
// stalls for long fills it and then stalls the literal channel. Reset clears
// the escape state, the length count and the queue; nothing is in flight
// after reset.
// ----------------------------------------------------------------------------
module string_escape_decoder
	import sed_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     literal_valid,
	output logic          literal_stall,
	input  wire in_item_t literal,
	output logic          decoded_valid,
	input  wire logic     decoded_stall,
	output out_item_t     decoded
);

	push_t push;
	logic  room;

	sed_decoder #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_decoder (
		.clk           (clk),
		.arst_n        (arst_n),
		.literal_valid (literal_valid),
		.literal_stall (literal_stall),
		.literal       (literal),
		.room          (room),
		.push          (push)
	);

	sed_out_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.room          (room),
		.decoded_valid (decoded_valid),
		.decoded_stall (decoded_stall),
		.decoded       (decoded)
	);

endmodule

`default_nettype wire
